// ----- design/tvp_pkg.sv -----
`timescale 1ns / 1ps
// shared types, register codes and saturation helpers for the trapezoid profile unit
// no dependencies

package tvp_pkg;

  localparam int VAL_W          = 24;
  localparam int TIME_W         = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int MAG_W          = 48;
  localparam int SQRT_STEPS     = 24;
  localparam int TICKS_DEFAULT  = 1000;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t VAL_MAX = 24'sh7FFFFF;
  localparam val_t VAL_MIN = 24'sh800000;
  localparam logic [TIME_W-1:0] TIME_SAT = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE = 3'd0,
    REG_ACCEL  = 3'd1,
    REG_DIST   = 3'd2,
    REG_VSTART = 3'd3,
    REG_VMAX   = 3'd4,
    REG_VEND   = 3'd5
  } cfg_reg_t;

  function automatic logic [VAL_W-1:0] mag24(input val_t v);
    val_t n;
    n = -v;
    return v[VAL_W-1] ? n : v;
  endfunction

  function automatic val_t sat24(input logic signed [41:0] v);
    if (v > 42'sd8388607) return VAL_MAX;
    if (v < -42'sd8388608) return VAL_MIN;
    return v[VAL_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] clamp_t(input logic signed [17:0] v);
    if (v < 18'sd0) return '0;
    if (v > 18'sd65535) return TIME_SAT;
    return v[TIME_W-1:0];
  endfunction

endpackage

// ----- design/tvp_mul.sv -----
`timescale 1ns / 1ps
// shift-and-add multiplier, one multiplier bit per cycle
// no package dependencies

module tvp_mul #(
  parameter int AW = 48,
  parameter int BW = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [AW-1:0]      mcand,
  input  logic [BW-1:0]      mplier,
  output logic               done,
  output logic [AW+BW-1:0]   product
);

  localparam int CW = $clog2(BW + 1);

  logic [AW+BW-1:0] sh;
  logic [BW-1:0]    mp;
  logic [CW-1:0]    cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        product <= '0;
        sh      <= (AW+BW)'(mcand);
        mp      <= mplier;
        cnt     <= CW'(BW);
      end else if (cnt != '0) begin
        if (mp[0]) product <= product + sh;
        sh  <= sh << 1;
        mp  <= mp >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) done <= 1'b1;
      end
    end
  end

endmodule

// ----- design/tvp_div.sv -----
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
// no package dependencies

module tvp_div #(
  parameter int NW = 72,
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem, quotient[NW-1]};
  assign diff  = trial - {1'b0, dreg};
  assign ge    = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= '0;
        dreg     <= divisor;
        quotient <= dividend;
        cnt      <= CW'(NW);
      end else if (cnt != '0) begin
        rem      <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quotient <= {quotient[NW-2:0], ge};
        cnt      <= cnt - 1'b1;
        if (cnt == CW'(1)) done <= 1'b1;
      end
    end
  end

endmodule

// ----- design/trapezoid_velocity_profile_unit.sv -----
`timescale 1ns / 1ps
// trapezoid velocity profile unit: planner and per-time query
// depends on tvp_pkg, tvp_mul, tvp_div

// One transaction at a time. A query whose time falls in a cruise or rest
// region skips the bit-serial multiplier (BW = 24 by default) and divider
// (PW = 48 + BW); an interpolated velocity uses both. A transaction with
// new_move first runs a plan on the multiplier and, with nonzero
// acceleration, the divider; a triangular or zero-acceleration plan also
// uses a 24-step square root. A finished result waits in the output
// register while the next transaction is accepted.

module trapezoid_velocity_profile_unit #(
  parameter int TICKS_PER_SECOND = tvp_pkg::TICKS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [tvp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tvp_pkg::VAL_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              new_move,
  input  logic [tvp_pkg::TIME_W-1:0]        time_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tvp_pkg::val_t                     accel_out,
  output tvp_pkg::val_t                     velocity_out,
  output logic                              move_done,
  output logic                              has_cruise,
  output tvp_pkg::val_t                     peak_velocity,
  output logic [tvp_pkg::TIME_W-1:0]        cruise_start_ms,
  output logic [tvp_pkg::TIME_W-1:0]        decel_start_ms,
  output logic [tvp_pkg::TIME_W-1:0]        end_ms
);

  localparam int TKW = $clog2(TICKS_PER_SECOND + 1);
  localparam int BW  = (TKW > tvp_pkg::VAL_W) ? TKW : tvp_pkg::VAL_W;
  localparam int MW  = tvp_pkg::MAG_W;
  localparam int PW  = MW + BW;
  localparam int DVW = (BW > MW) ? BW : MW;
  localparam int VW  = 51;
  localparam int QW  = 42;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_SQ   = 10'b0000000010,
    ST_DEN  = 10'b0000000100,
    ST_SQRT = 10'b0000001000,
    ST_RMUL = 10'b0000010000,
    ST_RDIV = 10'b0000100000,
    ST_PLAN = 10'b0001000000,
    ST_QMUL = 10'b0010000000,
    ST_QDIV = 10'b0100000000,
    ST_DONE = 10'b1000000000
  } state_t;

  state_t state;
  logic   run;
  logic   out_load;

  // configuration
  logic          enable;
  tvp_pkg::val_t accel, move_dist, vstart, vmax, vend;

  // stored plan
  logic [tvp_pkg::TIME_W-1:0] t1_r, t2_r, te_r;
  tvp_pkg::val_t              peak_r;
  logic                       cruise_r;

  // working registers
  logic [tvp_pkg::TIME_W-1:0] qt;
  logic                       zero_out;
  logic [1:0]                 sq_idx, r_idx;
  logic [MW-1:0]              sq_s, sq_m, sq_e, p_ad, den2;
  logic                       cruise_w;
  tvp_pkg::val_t              peak_w;
  logic signed [16:0]         r0, r1, r2;
  logic [MW-1:0]              sx, sres, sbit;
  logic [4:0]                 scnt;
  logic signed [QW-1:0]       qterm;

  logic [tvp_pkg::VAL_W-1:0] mag_a, mag_d, mag_vs, mag_vm, mag_ve;

  assign mag_a  = tvp_pkg::mag24(accel);
  assign mag_d  = tvp_pkg::mag24(move_dist);
  assign mag_vs = tvp_pkg::mag24(vstart);
  assign mag_vm = tvp_pkg::mag24(vmax);
  assign mag_ve = tvp_pkg::mag24(vend);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b1;
      accel     <= '0;
      move_dist <= '0;
      vstart    <= '0;
      vmax      <= '0;
      vend      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        tvp_pkg::REG_ENABLE: enable    <= cfg_data[0];
        tvp_pkg::REG_ACCEL:  accel     <= cfg_data;
        tvp_pkg::REG_DIST:   move_dist <= cfg_data;
        tvp_pkg::REG_VSTART: vstart    <= cfg_data;
        tvp_pkg::REG_VMAX:   vmax      <= cfg_data;
        tvp_pkg::REG_VEND:   vend      <= cfg_data;
        default: ;
      endcase
    end
  end

  // plan arithmetic
  logic signed [VW-1:0] e_s, e_m, e_e, e_ad2, n_term, d1, d3, x_term;
  logic                 cruise_cond;
  logic [49:0]          s_sum;

  always_comb begin
    e_s    = $signed(VW'(sq_s));
    e_m    = $signed(VW'(sq_m));
    e_e    = $signed(VW'(sq_e));
    e_ad2  = $signed(VW'(p_ad)) <<< 1;
    n_term = (e_m <<< 1) - e_s - e_e;
    d1     = e_m - e_s;
    d3     = e_m - e_e;
    if (d1 < 0) d1 = -d1;
    if (d3 < 0) d3 = -d3;
    x_term = e_ad2 - d1 - d3;
    cruise_cond = (accel != '0) && (n_term <= e_ad2);
    s_sum  = {1'b0, p_ad, 1'b0} + 50'(sq_s) + 50'(sq_e);
  end

  // ratio operands
  logic signed [VW-1:0] num;
  logic [VW-1:0]        num_abs;
  logic                 num_neg, den_neg, r_skip;
  logic signed [16:0]   skip_val;

  always_comb begin
    case (r_idx)
      2'd0:    num = x_term;
      2'd1:    num = VW'(peak_w) - VW'(vstart);
      default: num = VW'(peak_w) - VW'(vend);
    endcase
    num_neg  = num[VW-1];
    num_abs  = num_neg ? -num : num;
    den_neg  = (r_idx != 2'd0) && accel[tvp_pkg::VAL_W-1];
    r_skip   = (r_idx == 2'd0) && (!cruise_w || vmax == '0);
    if (!cruise_w || x_term == '0) skip_val = '0;
    else if (x_term > 0)           skip_val = 17'sd65535;
    else                           skip_val = -17'sd65535;
  end

  // query region
  logic                       q_before, q_hold, q_dec, q_need;
  logic [tvp_pkg::TIME_W-1:0] q_dt;

  assign q_before = qt < t1_r;
  assign q_hold   = qt <= t2_r;
  assign q_dec    = qt < te_r;
  assign q_need   = q_before || (!q_hold && q_dec);
  assign q_dt     = q_before ? qt : qt - t2_r;

  // shared serial units
  logic           mul_start, mul_done, div_start, div_done;
  logic [MW-1:0]  mul_a;
  logic [BW-1:0]  mul_b;
  logic [PW-1:0]  mul_p, div_q;
  logic [DVW-1:0] div_d;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ: begin
        case (sq_idx)
          2'd0:    begin mul_a = MW'(mag_vs); mul_b = BW'(mag_vs); end
          2'd1:    begin mul_a = MW'(mag_vm); mul_b = BW'(mag_vm); end
          2'd2:    begin mul_a = MW'(mag_ve); mul_b = BW'(mag_ve); end
          default: begin mul_a = MW'(mag_a);  mul_b = BW'(mag_d);  end
        endcase
      end
      ST_DEN:  begin mul_a = MW'(mag_a);         mul_b = BW'(mag_vm); end
      ST_RMUL: begin mul_a = num_abs[MW-1:0];    mul_b = BW'(TICKS_PER_SECOND); end
      ST_QMUL: begin mul_a = MW'(mag_a);         mul_b = BW'(q_dt); end
      default: ;
    endcase
    if (state == ST_QDIV) div_d = DVW'(TICKS_PER_SECOND);
    else if (r_idx == 2'd0) div_d = DVW'(den2);
    else div_d = DVW'(mag_a);
  end

  assign mul_start = !run && ((state == ST_SQ) || (state == ST_DEN && cruise_cond) ||
                              (state == ST_RMUL && !r_skip) || (state == ST_QMUL && q_need));
  assign div_start = !run && (state == ST_RDIV || state == ST_QDIV);

  tvp_mul #(.AW(MW), .BW(BW)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  tvp_div #(.NW(PW), .DW(DVW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_p),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // ratio result and sqrt step
  logic [16:0]        r_mag;
  logic signed [16:0] r_val;
  logic [MW-1:0]      s_trial;

  always_comb begin
    r_mag   = (|div_q[PW-1:16]) ? 17'd65535 : {1'b0, div_q[15:0]};
    r_val   = (num_neg ^ den_neg) ? -$signed(r_mag) : $signed(r_mag);
    s_trial = sres + sbit;
  end

  // plan boundaries
  logic [tvp_pkg::TIME_W-1:0] t1_v, t2_v, te_v;
  logic signed [17:0]         sum2, sume;

  always_comb begin
    t1_v = tvp_pkg::clamp_t(18'(r1));
    sum2 = $signed({2'b00, t1_v}) + 18'(r0);
    t2_v = cruise_w ? tvp_pkg::clamp_t(sum2) : t1_v;
    sume = $signed({2'b00, t2_v}) + 18'(r2);
    te_v = tvp_pkg::clamp_t(sume);
    if (!cruise_w && accel == '0) begin
      t1_v = tvp_pkg::TIME_SAT;
      t2_v = tvp_pkg::TIME_SAT;
      te_v = tvp_pkg::TIME_SAT;
    end
  end

  // query result
  tvp_pkg::val_t acc_v, vel_v;
  logic signed [QW-1:0] q_ext;

  always_comb begin
    q_ext = $signed(QW'(div_q[QW-3:0]));
    if (q_before) acc_v = accel;
    else if (qt < t2_r) acc_v = '0;
    else if (q_dec) acc_v = (accel == tvp_pkg::VAL_MIN) ? tvp_pkg::VAL_MAX : -accel;
    else acc_v = '0;
    if (q_before) vel_v = tvp_pkg::sat24(QW'(vstart) + qterm);
    else if (q_hold) vel_v = peak_r;
    else if (q_dec) vel_v = tvp_pkg::sat24(QW'(peak_r) - qterm);
    else vel_v = vend;
  end

  assign in_stall = (state != ST_IDLE);
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      run       <= 1'b0;
      t1_r      <= '0;
      t2_r      <= '0;
      te_r      <= '0;
      peak_r    <= '0;
      cruise_r  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            qt       <= time_ms;
            zero_out <= !enable;
            if (!enable) state <= ST_DONE;
            else if (new_move) begin
              sq_idx <= '0;
              state  <= ST_SQ;
            end else state <= ST_QMUL;
          end
        end
        ST_SQ: begin
          if (!run) run <= 1'b1;
          else if (mul_done) begin
            run <= 1'b0;
            case (sq_idx)
              2'd0:    sq_s <= mul_p[MW-1:0];
              2'd1:    sq_m <= mul_p[MW-1:0];
              2'd2:    sq_e <= mul_p[MW-1:0];
              default: p_ad <= mul_p[MW-1:0];
            endcase
            sq_idx <= sq_idx + 2'd1;
            if (sq_idx == 2'd3) state <= ST_DEN;
          end
        end
        ST_DEN: begin
          if (!run) begin
            cruise_w <= cruise_cond;
            peak_w   <= vmax;
            if (cruise_cond) run <= 1'b1;
            else begin
              sx    <= s_sum[MW:1];
              sres  <= '0;
              sbit  <= MW'(1) << (2 * tvp_pkg::SQRT_STEPS - 2);
              scnt  <= 5'(tvp_pkg::SQRT_STEPS);
              state <= ST_SQRT;
            end
          end else if (mul_done) begin
            run   <= 1'b0;
            den2  <= {mul_p[MW-2:0], 1'b0};
            r_idx <= '0;
            state <= ST_RMUL;
          end
        end
        ST_SQRT: begin
          if (scnt != '0) begin
            if (sx >= s_trial) begin
              sx   <= sx - s_trial;
              sres <= (sres >> 1) + sbit;
            end else sres <= sres >> 1;
            sbit <= sbit >> 2;
            scnt <= scnt - 5'd1;
          end else begin
            peak_w <= (|sres[MW-1:tvp_pkg::VAL_W-1]) ? tvp_pkg::VAL_MAX
                                                     : {1'b0, sres[tvp_pkg::VAL_W-2:0]};
            r_idx  <= '0;
            state  <= (accel == '0) ? ST_PLAN : ST_RMUL;
          end
        end
        ST_RMUL: begin
          if (!run) begin
            if (r_skip) begin
              r0    <= skip_val;
              r_idx <= 2'd1;
            end else run <= 1'b1;
          end else if (mul_done) begin
            run   <= 1'b0;
            state <= ST_RDIV;
          end
        end
        ST_RDIV: begin
          if (!run) run <= 1'b1;
          else if (div_done) begin
            run <= 1'b0;
            case (r_idx)
              2'd0:    r0 <= r_val;
              2'd1:    r1 <= r_val;
              default: r2 <= r_val;
            endcase
            if (r_idx == 2'd2) state <= ST_PLAN;
            else begin
              r_idx <= r_idx + 2'd1;
              state <= ST_RMUL;
            end
          end
        end
        ST_PLAN: begin
          t1_r     <= t1_v;
          t2_r     <= t2_v;
          te_r     <= te_v;
          peak_r   <= peak_w;
          cruise_r <= cruise_w;
          state    <= ST_QMUL;
        end
        ST_QMUL: begin
          if (!run) begin
            if (q_need) run <= 1'b1;
            else state <= ST_DONE;
          end else if (mul_done) begin
            run   <= 1'b0;
            state <= ST_QDIV;
          end
        end
        ST_QDIV: begin
          if (!run) run <= 1'b1;
          else if (div_done) begin
            run   <= 1'b0;
            qterm <= accel[tvp_pkg::VAL_W-1] ? -q_ext : q_ext;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            if (zero_out) begin
              accel_out       <= '0;
              velocity_out    <= '0;
              move_done       <= 1'b0;
              has_cruise      <= 1'b0;
              peak_velocity   <= '0;
              cruise_start_ms <= '0;
              decel_start_ms  <= '0;
              end_ms          <= '0;
            end else begin
              accel_out       <= acc_v;
              velocity_out    <= vel_v;
              move_done       <= !q_dec;
              has_cruise      <= cruise_r;
              peak_velocity   <= peak_r;
              cruise_start_ms <= t1_r;
              decel_start_ms  <= t2_r;
              end_ms          <= te_r;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  a_triangle_flat: assert property (@(posedge clk) disable iff (rst)
    !cruise_r |-> (t1_r == t2_r))
    else $error("plan without cruise has distinct phase boundaries");

  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && !enable) |->
      (accel_out == '0 && velocity_out == '0 && peak_velocity == '0 && end_ms == '0))
    else $error("disabled profile gave a nonzero transaction");

endmodule

// ----- test/tvp_checker.sv -----
`timescale 1ns / 1ps
// profile checker: watches the config port and both channels, predicts and compares
// depends on tvp_pkg

module tvp_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tvp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tvp_pkg::VAL_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          new_move,
  input  logic [tvp_pkg::TIME_W-1:0]    time_ms,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  tvp_pkg::val_t                 accel_out,
  input  tvp_pkg::val_t                 velocity_out,
  input  logic                          move_done,
  input  logic                          has_cruise,
  input  tvp_pkg::val_t                 peak_velocity,
  input  logic [tvp_pkg::TIME_W-1:0]    cruise_start_ms,
  input  logic [tvp_pkg::TIME_W-1:0]    decel_start_ms,
  input  logic [tvp_pkg::TIME_W-1:0]    end_ms,
  output int                            pending,
  output int                            errors
);

  localparam longint TICKS = 1000;
  localparam longint T_SAT = 65535;

  typedef struct {
    logic [23:0] accel;
    logic [23:0] vel;
    logic        done;
    logic        cruise;
    logic [23:0] peak;
    logic [15:0] t_cruise;
    logic [15:0] t_decel;
    logic [15:0] t_end;
  } profile_result_t;

  profile_result_t profile_q[$];

  logic   enable_r;
  longint accel_r, dist_r, vstart_r, vmax_r, vend_r;
  longint plan_t1, plan_t2, plan_te, plan_peak;
  logic   plan_cruise;

  function automatic longint clip_val(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint clip_time(longint v);
    if (v < 0) return 0;
    if (v > T_SAT) return T_SAT;
    return v;
  endfunction

  function automatic longint absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  // num * ticks / den, truncated, magnitude saturated
  function automatic longint time_ratio(longint num, longint den);
    longint m;
    m = absval(num) * TICKS / absval(den);
    if (m > T_SAT) m = T_SAT;
    return ((num < 0) != (den < 0)) ? -m : m;
  endfunction

  function automatic longint int_sqrt(longint unsigned x);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > x) bits >>= 2;
    while (bits != 0) begin
      if (x >= res + bits) begin
        x = x - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic void plan_move();
    longint aa, ad, n, n1, n3, x, dt2;
    longint unsigned s;
    aa = absval(accel_r);
    ad = absval(dist_r);
    n = 2 * vmax_r * vmax_r - vstart_r * vstart_r - vend_r * vend_r;
    if (accel_r != 0 && n <= 2 * aa * ad) begin
      n1 = absval(vmax_r * vmax_r - vstart_r * vstart_r);
      n3 = absval(vmax_r * vmax_r - vend_r * vend_r);
      x = 2 * aa * ad - n1 - n3;
      if (vmax_r == 0) dt2 = x > 0 ? T_SAT : (x < 0 ? -T_SAT : 0);
      else dt2 = time_ratio(x, 2 * aa * absval(vmax_r));
      plan_peak = vmax_r;
      plan_t1 = clip_time(time_ratio(vmax_r - vstart_r, accel_r));
      plan_t2 = clip_time(plan_t1 + dt2);
      plan_te = clip_time(plan_t2 + time_ratio(vmax_r - vend_r, accel_r));
      plan_cruise = 1'b1;
    end else begin
      s = 2 * absval(accel_r * dist_r) + vstart_r * vstart_r + vend_r * vend_r;
      plan_peak = clip_val(int_sqrt(s >> 1));
      if (accel_r == 0) begin
        plan_t1 = T_SAT;
        plan_t2 = T_SAT;
        plan_te = T_SAT;
      end else begin
        plan_t1 = clip_time(time_ratio(plan_peak - vstart_r, accel_r));
        plan_t2 = plan_t1;
        plan_te = clip_time(plan_t1 + time_ratio(plan_peak - vend_r, accel_r));
      end
      plan_cruise = 1'b0;
    end
  endfunction

  function automatic profile_result_t profile_at(logic replan, longint t);
    profile_result_t r;
    longint acc, vel;
    r = '{default: '0};
    if (!enable_r) return r;
    if (replan) plan_move();
    if (t < plan_t1) acc = accel_r;
    else if (t < plan_t2) acc = 0;
    else if (t < plan_te) acc = clip_val(-accel_r);
    else acc = 0;
    if (t < plan_t1) vel = vstart_r + accel_r * t / TICKS;
    else if (t <= plan_t2) vel = plan_peak;
    else if (t < plan_te) vel = plan_peak - accel_r * (t - plan_t2) / TICKS;
    else vel = vend_r;
    vel = clip_val(vel);
    r.accel = acc[23:0];
    r.vel = vel[23:0];
    r.done = t >= plan_te;
    r.cruise = plan_cruise;
    r.peak = plan_peak[23:0];
    r.t_cruise = plan_t1[15:0];
    r.t_decel = plan_t2[15:0];
    r.t_end = plan_te[15:0];
    return r;
  endfunction

  always @(posedge clk) begin
    profile_result_t exp_r;
    if (rst) begin
      profile_q.delete();
      enable_r = 1'b1;
      accel_r = 0; dist_r = 0; vstart_r = 0; vmax_r = 0; vend_r = 0;
      plan_t1 = 0; plan_t2 = 0; plan_te = 0; plan_peak = 0; plan_cruise = 1'b0;
      errors = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          tvp_pkg::REG_ENABLE: enable_r = cfg_data[0];
          tvp_pkg::REG_ACCEL:  accel_r  = longint'($signed(cfg_data));
          tvp_pkg::REG_DIST:   dist_r   = longint'($signed(cfg_data));
          tvp_pkg::REG_VSTART: vstart_r = longint'($signed(cfg_data));
          tvp_pkg::REG_VMAX:   vmax_r   = longint'($signed(cfg_data));
          tvp_pkg::REG_VEND:   vend_r   = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (profile_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transaction at %0t", $realtime);
        end else begin
          exp_r = profile_q.pop_front();
          if (accel_out !== exp_r.accel || velocity_out !== exp_r.vel ||
              move_done !== exp_r.done || has_cruise !== exp_r.cruise ||
              peak_velocity !== exp_r.peak || cruise_start_ms !== exp_r.t_cruise ||
              decel_start_ms !== exp_r.t_decel || end_ms !== exp_r.t_end) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at %0t: exp acc %h vel %h done %b cr %b pk %h t %h %h %h",
                       $realtime, exp_r.accel, exp_r.vel, exp_r.done, exp_r.cruise,
                       exp_r.peak, exp_r.t_cruise, exp_r.t_decel, exp_r.t_end,
                       "\n  got acc %h vel %h done %b cr %b pk %h t %h %h %h",
                       accel_out, velocity_out, move_done, has_cruise, peak_velocity,
                       cruise_start_ms, decel_start_ms, end_ms);
          end
        end
      end
      if (in_valid && !in_stall) profile_q.push_back(profile_at(new_move, longint'(time_ms)));
    end
    pending = profile_q.size();
  end

endmodule

// ----- test/tb_trapezoid_velocity_profile_unit.sv -----
`timescale 1ns / 1ps
// testbench top for the trapezoid velocity profile unit: stimulus and verdict
// depends on tvp_pkg, trapezoid_velocity_profile_unit and tvp_checker

module tb_trapezoid_velocity_profile_unit;

  localparam logic [tvp_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [tvp_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int ITEM_TARGET = 850;
  localparam int CYCLE_LIMIT = 4000000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [tvp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tvp_pkg::VAL_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          new_move = 1'b0;
  logic [tvp_pkg::TIME_W-1:0]    time_ms = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  tvp_pkg::val_t                 accel_out, velocity_out, peak_velocity;
  logic                          move_done, has_cruise;
  logic [tvp_pkg::TIME_W-1:0]    cruise_start_ms, decel_start_ms, end_ms;
  int                            pending, errors;
  int                            items_sent = 0;
  int                            cycles = 0;
  logic                          idle_on = 1'b1;

  always #4 clk = ~clk;

  trapezoid_velocity_profile_unit u_dut (.*);

  tvp_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_trapezoid_velocity_profile_unit failed");
      $finish;
    end
  end

  // receiver back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && !rst && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic cfg_put(logic [tvp_pkg::CFG_IDX_W-1:0] idx, logic [tvp_pkg::VAL_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic cfg_done();
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send(logic nm, logic [tvp_pkg::TIME_W-1:0] t);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    new_move <= nm;
    time_ms  <= t;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  function automatic logic [tvp_pkg::VAL_W-1:0] pick_val();
    logic [tvp_pkg::VAL_W-1:0] v;
    int w;
    w = $urandom_range(1, 23);
    v = tvp_pkg::VAL_W'($urandom & ((32'd1 << w) - 1));
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return '0;
      3: return tvp_pkg::VAL_W'($urandom);
      default: return $urandom_range(0, 1) ? -v : v;
    endcase
  endfunction

  function automatic logic [tvp_pkg::TIME_W-1:0] pick_time();
    int w;
    w = $urandom_range(1, 16);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return tvp_pkg::TIME_SAT;
      2: return tvp_pkg::TIME_W'($urandom);
      default: return tvp_pkg::TIME_W'($urandom & ((32'd1 << w) - 1));
    endcase
  endfunction

  task automatic set_profile(logic [tvp_pkg::VAL_W-1:0] a, logic [tvp_pkg::VAL_W-1:0] d,
                             logic [tvp_pkg::VAL_W-1:0] vs, logic [tvp_pkg::VAL_W-1:0] vm,
                             logic [tvp_pkg::VAL_W-1:0] ve);
    cfg_put(tvp_pkg::REG_ACCEL, a);
    cfg_put(tvp_pkg::REG_DIST, d);
    cfg_put(tvp_pkg::REG_VSTART, vs);
    cfg_put(tvp_pkg::REG_VMAX, vm);
    cfg_put(tvp_pkg::REG_VEND, ve);
    cfg_done();
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: zero acceleration saturates the plan
    send(1'b1, 16'd0);
    send(1'b0, tvp_pkg::TIME_SAT);
    wait_idle();

    // cruise fits
    set_profile(24'd655360, 24'd327680, 24'd0, 24'd131072, 24'd0);
    send(1'b1, 16'd0);
    send(1'b0, 16'd100);
    send(1'b0, 16'd200);
    send(1'b0, 16'd300);
    send(1'b0, 16'd600);
    wait_idle();

    // extremes with minimum acceleration
    set_profile(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'hFFFFFF);
    send(1'b1, 16'd1);
    send(1'b0, 16'd32768);
    wait_idle();

    // zero max velocity with cruise
    set_profile(24'd65536, 24'd65536, 24'd0, 24'd0, 24'd0);
    send(1'b1, 16'd5);
    wait_idle();

    // disabled profile keeps the stored plan
    cfg_put(tvp_pkg::REG_ENABLE, 24'd0);
    cfg_done();
    send(1'b1, 16'd10);
    wait_idle();
    cfg_put(tvp_pkg::REG_ENABLE, 24'hFFFFFF);
    cfg_done();
    send(1'b0, 16'd10);
    wait_idle();

    // live acceleration against the stored plan, spare indexes ignored
    cfg_put(tvp_pkg::REG_ACCEL, 24'd131072);
    cfg_put(REG_SPARE_A, tvp_pkg::VAL_W'($urandom));
    cfg_put(REG_SPARE_B, tvp_pkg::VAL_W'($urandom));
    cfg_done();
    send(1'b0, 16'd3);
    send(1'b0, 16'd1);
    wait_idle();

    while (items_sent < ITEM_TARGET) begin
      idle_on = (items_sent < ITEM_TARGET - 150) && ($urandom_range(0, 3) != 0);
      cfg_put(tvp_pkg::REG_ENABLE,
              {(tvp_pkg::VAL_W-1)'($urandom), ($urandom_range(0, 9) != 0)});
      if ($urandom_range(0, 7) == 0) cfg_put(REG_SPARE_A, tvp_pkg::VAL_W'($urandom));
      set_profile(pick_val(), pick_val(), pick_val(), pick_val(), pick_val());
      n = $urandom_range(4, 20);
      send($urandom_range(0, 7) != 0, pick_time());
      repeat (n - 1) send($urandom_range(0, 14) == 0, pick_time());
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_trapezoid_velocity_profile_unit passed");
    end else begin
      $display("tb_trapezoid_velocity_profile_unit failed");
    end
    $finish;
  end

endmodule
